@@ hdl/vpa_pkg.sv @@
// Shared types and constants for the virial pressure accumulator.
// No dependencies; every other file of the block imports this package.
package vpa_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int ACC_WIDTH_DEF  = 64;

  localparam int AXES        = 3;
  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 9 * FIELD_W;
  localparam int FRAC_BITS   = 16;
  localparam int SCALE_W     = 32;
  localparam int OUT_W       = 48;
  localparam int OUT_TDATA_W = 4 * OUT_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // Division of the pressure sum by three through a reciprocal multiply.
  localparam int SUM3_W     = OUT_W + 2;
  localparam int MAG_W      = OUT_W + 1;
  localparam int RECIP_W    = 50;
  localparam int SPLIT_W    = 25;
  localparam int DIV3_SHIFT = 51;
  localparam int FULL_W     = MAG_W + RECIP_W + 1;
  localparam logic [RECIP_W-1:0] DIV3_RECIP = 50'd750599937895083;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

@@ hdl/vpa_front.sv @@
// Front end: takes atom requests and forms the three r*F products.
// Depends on vpa_pkg; feeds the entry queue.
module vpa_front import vpa_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ENTRY_W    = 6 * DATA_WIDTH_DEF + 3 * DATA_WIDTH_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  fifo_status_t          fifo_st,
  output logic                  fifo_push,
  output logic [ENTRY_W-1:0]    fifo_wdata
);

  localparam int PW = 2 * DATA_WIDTH;

  logic                         valid_r;
  logic                         valid_nxt;
  logic                         load;
  logic signed [PW-1:0]         prod_nxt [AXES];
  logic signed [PW-1:0]         prod_r   [AXES];
  logic [DATA_WIDTH-1:0]        kin_r    [AXES];
  logic                         last_r;

  assign in_tready = !valid_r || !fifo_st.full;
  assign load      = in_tvalid && in_tready;
  assign fifo_push = valid_r && !fifo_st.full;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (fifo_push) begin
      valid_nxt = 1'b0;
    end
    for (int i = 0; i < AXES; i++) begin
      prod_nxt[i] = $signed(in_tdata[i*FIELD_W +: DATA_WIDTH])
                  * $signed(in_tdata[(AXES+i)*FIELD_W +: DATA_WIDTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < AXES; i++) begin
        prod_r[i] <= prod_nxt[i];
        kin_r[i]  <= in_tdata[(2*AXES+i)*FIELD_W +: DATA_WIDTH];
      end
      last_r <= in_tlast;
    end
  end

  assign fifo_wdata = {last_r, kin_r[2], kin_r[1], kin_r[0], prod_r[2], prod_r[1], prod_r[0]};

endmodule

@@ hdl/vpa_fifo.sv @@
// Short entry queue between the front end and the accumulating back end.
// Depends on vpa_pkg for depth and status type.
module vpa_fifo import vpa_pkg::*; #(
  parameter int WIDTH = 6 * DATA_WIDTH_DEF + 3 * DATA_WIDTH_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output fifo_status_t     status
);

  logic [WIDTH-1:0]      mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_push;
  logic                  do_pop;

  assign status.full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ hdl/vpa_back.sv @@
// Back end: saturating virial sums, kinetic add, scaling, clamp and mean.
// Depends on vpa_pkg; drains the entry queue and drives the result channel.
module vpa_back import vpa_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  parameter int ENTRY_W    = 6 * DATA_WIDTH_DEF + 3 * DATA_WIDTH_DEF + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SCALE_W-1:0]     scale,
  input  fifo_status_t           fifo_st,
  input  logic [ENTRY_W-1:0]     fifo_rdata,
  output logic                   fifo_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int PW    = 2 * DATA_WIDTH;
  localparam int KW    = DATA_WIDTH + FRAC_BITS + 2;
  localparam int W_A   = (ACC_WIDTH > PW) ? ACC_WIDTH : PW;
  localparam int SUM_W = ((W_A > KW) ? W_A : KW) + 1;
  localparam int QW    = ACC_WIDTH + 1;
  localparam int MH_W  = MAG_W - SPLIT_W;
  localparam int HH_W  = MH_W + RECIP_W - SPLIT_W;
  localparam int HL_W  = MH_W + SPLIT_W;
  localparam int LH_W  = SPLIT_W + RECIP_W - SPLIT_W;
  localparam int LL_W  = 2 * SPLIT_W;

  localparam logic signed [SUM_W-1:0] ACC_MAX_W =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN_W =
    {{(SUM_W-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [QW-1:0] OUT_MAX_Q = {{(QW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [QW-1:0] OUT_MIN_Q = {{(QW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic adv;
  logic take_last;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic out_valid_r;

  logic signed [PW-1:0]          prod    [AXES];
  logic signed [SUM_W-1:0]       acc_sum [AXES];
  logic signed [SUM_W-1:0]       acc_sat [AXES];
  logic signed [ACC_WIDTH-1:0]   acc_nxt [AXES];
  logic signed [ACC_WIDTH-1:0]   acc_r   [AXES];
  logic signed [ACC_WIDTH-1:0]   vir_r   [AXES];
  logic [DATA_WIDTH-1:0]         kin_r   [AXES];
  logic signed [SUM_W-1:0]       tot_sum [AXES];
  logic signed [SUM_W-1:0]       tot_sat [AXES];
  logic signed [ACC_WIDTH-1:0]   tot_r   [AXES];
  logic [2*SCALE_W-1:0]          p_lo    [AXES];
  logic signed [ACC_WIDTH:0]     p_hi    [AXES];
  logic [2*SCALE_W-1:0]          plo_r   [AXES];
  logic signed [ACC_WIDTH-1:0]   phi_r   [AXES];
  logic signed [QW-1:0]          q       [AXES];
  logic signed [QW-1:0]          q_sat   [AXES];
  logic signed [OUT_W-1:0]       press_r [AXES];
  logic signed [OUT_W-1:0]       press5_r[AXES];
  logic signed [OUT_W-1:0]       press6_r[AXES];
  logic signed [SUM3_W-1:0]      sum3;
  logic [SUM3_W-1:0]             mag_full;
  logic [MAG_W-1:0]              mag_r;
  logic                          neg5_r;
  logic                          neg6_r;
  logic [HH_W-1:0]               hh_r;
  logic [HL_W-1:0]               hl_r;
  logic [LH_W-1:0]               lh_r;
  logic [LL_W-1:0]               ll_r;
  logic [FULL_W-1:0]             full;
  logic [MAG_W-1:0]              quo;
  logic [MAG_W-1:0]              mean_w;
  logic [OUT_TDATA_W-1:0]        out_data_r;

  assign adv        = !out_valid_r || out_tready;
  assign fifo_pop   = adv && !fifo_st.empty;
  assign take_last  = fifo_rdata[ENTRY_W-1];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      prod[i]    = $signed(fifo_rdata[i*PW +: PW]);
      acc_sum[i] = $signed({{(SUM_W-ACC_WIDTH){acc_r[i][ACC_WIDTH-1]}}, acc_r[i]})
                 + $signed({{(SUM_W-PW){prod[i][PW-1]}}, prod[i]});
      acc_sat[i] = (acc_sum[i] > ACC_MAX_W) ? ACC_MAX_W :
                   (acc_sum[i] < ACC_MIN_W) ? ACC_MIN_W : acc_sum[i];
      acc_nxt[i] = acc_r[i];
      if (fifo_pop) begin
        acc_nxt[i] = take_last ? '0 : acc_sat[i][ACC_WIDTH-1:0];
      end

      tot_sum[i] = $signed({{(SUM_W-ACC_WIDTH){vir_r[i][ACC_WIDTH-1]}}, vir_r[i]})
                 + $signed({{(SUM_W-DATA_WIDTH-FRAC_BITS-1){1'b0}}, kin_r[i],
                            {(FRAC_BITS+1){1'b0}}});
      tot_sat[i] = (tot_sum[i] > ACC_MAX_W) ? ACC_MAX_W :
                   (tot_sum[i] < ACC_MIN_W) ? ACC_MIN_W : tot_sum[i];

      p_lo[i] = tot_r[i][SCALE_W-1:0] * scale;
      p_hi[i] = $signed(tot_r[i][ACC_WIDTH-1:SCALE_W]) * $signed({1'b0, scale});

      q[i] = $signed({{(QW-ACC_WIDTH){phi_r[i][ACC_WIDTH-1]}}, phi_r[i]})
           + $signed({{(QW-SCALE_W){1'b0}}, plo_r[i][2*SCALE_W-1:SCALE_W]});
      q_sat[i] = (q[i] > OUT_MAX_Q) ? OUT_MAX_Q : (q[i] < OUT_MIN_Q) ? OUT_MIN_Q : q[i];
    end

    sum3 = $signed({{(SUM3_W-OUT_W){press_r[0][OUT_W-1]}}, press_r[0]})
         + $signed({{(SUM3_W-OUT_W){press_r[1][OUT_W-1]}}, press_r[1]})
         + $signed({{(SUM3_W-OUT_W){press_r[2][OUT_W-1]}}, press_r[2]});
    mag_full = sum3[SUM3_W-1] ? (~sum3 + 1'b1) : sum3;

    full = (FULL_W'(hh_r) << (2 * SPLIT_W))
         + ((FULL_W'(hl_r) + FULL_W'(lh_r)) << SPLIT_W)
         + FULL_W'(ll_r);
    quo    = full[DIV3_SHIFT +: MAG_W];
    mean_w = neg6_r ? (~quo + 1'b1) : quo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        acc_r[i] <= '0;
      end
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < AXES; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
      if (adv) begin
        v1_r        <= fifo_pop && take_last;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        v4_r        <= v3_r;
        v5_r        <= v4_r;
        v6_r        <= v5_r;
        out_valid_r <= v6_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        vir_r[i]    <= acc_sat[i][ACC_WIDTH-1:0];
        kin_r[i]    <= fifo_rdata[AXES*PW + i*DATA_WIDTH +: DATA_WIDTH];
        tot_r[i]    <= tot_sat[i][ACC_WIDTH-1:0];
        plo_r[i]    <= p_lo[i];
        phi_r[i]    <= p_hi[i][ACC_WIDTH-1:0];
        press_r[i]  <= q_sat[i][OUT_W-1:0];
        press5_r[i] <= press_r[i];
        press6_r[i] <= press5_r[i];
      end
      mag_r      <= mag_full[MAG_W-1:0];
      neg5_r     <= sum3[SUM3_W-1];
      hh_r       <= mag_r[MAG_W-1:SPLIT_W] * DIV3_RECIP[RECIP_W-1:SPLIT_W];
      hl_r       <= mag_r[MAG_W-1:SPLIT_W] * DIV3_RECIP[SPLIT_W-1:0];
      lh_r       <= mag_r[SPLIT_W-1:0] * DIV3_RECIP[RECIP_W-1:SPLIT_W];
      ll_r       <= mag_r[SPLIT_W-1:0] * DIV3_RECIP[SPLIT_W-1:0];
      neg6_r     <= neg5_r;
      out_data_r <= {mean_w[OUT_W-1:0], press6_r[2], press6_r[1], press6_r[0]};
    end
  end

endmodule

@@ hdl/virial_pressure_accumulator.sv @@
// Top level of the virial pressure accumulator: front end, entry queue, back end.
// Depends on vpa_pkg, vpa_front, vpa_fifo and vpa_back.
//
//   Channel   Direction   Handshake                 Payload
//   in_       sink        in_tvalid / in_tready     in_tdata, in_tlast (last atom)
//   out_      source      out_tvalid / out_tready   out_tdata
//   cfg_      sink        cfg_wr_en                 cfg_wr_data (scale register)
//
// One atom request is taken every cycle unless the front-end register is held by a full
// queue; the saturating add of each virial sum, combinational into its register, sets that rate.
// A result is offered once its last atom has passed the front-end register, the queue and
// the back-end register stages, and it leaves when out_tready is high.
// Reset clears the sums, the scale register and all valid flags.
// A stalled output holds the back end; the four-entry queue then absorbs the front end.
module virial_pressure_accumulator import vpa_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pos_x, pos_y, pos_z, force_x, force_y, force_z, kinetic_x, kinetic_y, kinetic_z
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // press_xx, press_yy, press_zz, press_mean
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [SCALE_W-1:0]     cfg_wr_data
);

  localparam int ENTRY_W = 6 * DATA_WIDTH + 3 * DATA_WIDTH + 1;
  localparam int PEND_W  = 5;

  logic [SCALE_W-1:0] scale_r;
  fifo_status_t       fifo_st;
  logic               fifo_push;
  logic               fifo_pop;
  logic [ENTRY_W-1:0] fifo_wdata;
  logic [ENTRY_W-1:0] fifo_rdata;
  logic [PEND_W-1:0]  pend_r;
  logic [PEND_W-1:0]  pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  vpa_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .fifo_st    (fifo_st),
    .fifo_push  (fifo_push),
    .fifo_wdata (fifo_wdata)
  );

  vpa_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fifo_push),
    .wdata  (fifo_wdata),
    .pop    (fifo_pop),
    .rdata  (fifo_rdata),
    .status (fifo_st)
  );

  vpa_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .scale      (scale_r),
    .fifo_st    (fifo_st),
    .fifo_rdata (fifo_rdata),
    .fifo_pop   (fifo_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Count of last-atom requests whose result has not yet been taken.
  always_comb begin
    pend_nxt = pend_r;
    if (in_tvalid && in_tready && in_tlast) begin
      pend_nxt = pend_nxt + 1'b1;
    end
    if (out_tvalid && out_tready) begin
      pend_nxt = pend_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_fifo_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_st.full && fifo_st.empty))
    else $error("Queue reports full and empty at once.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> fifo_st.full)
    else $error("Input stalled while the queue has room.");

  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pend_r != '0))
    else $error("Result offered without a pending last atom.");

endmodule
